[design/stream_find_replace_macros.svh]
// assertion helpers shared by the stream find/replace design
`ifndef STREAM_FIND_REPLACE_MACROS_SVH
`define STREAM_FIND_REPLACE_MACROS_SVH

// condition that must hold at every clock edge outside reset
`define SFR_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// same-cycle implication
`define SFR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/sfr_pkg.sv]
`default_nettype none

package sfr_pkg;

   // field widths
   localparam int BYTE_W = 8;
   localparam int LEN_W  = 4;

   // register port geometry: four 64-bit registers at 8-byte spacing
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_LSB    = 3;
   localparam int CSR_ADDR_W = CSR_IDX_W + CSR_LSB;

   // bytes held by one pattern register
   localparam int PAT_BYTES = CSR_DATA_W / BYTE_W;

   // default size limits
   localparam int PATTERN_MAX_DEF = 8;
   localparam int REPLACE_MAX_DEF = 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SEARCH_PATTERN  = 2'd0,
      REG_SEARCH_LENGTH   = 2'd1,
      REG_REPLACE_PATTERN = 2'd2,
      REG_REPLACE_LENGTH  = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              in_last;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              out_valid;
      logic              out_last;
   } rsp_type;

endpackage

`default_nettype wire

[design/stream_find_replace.sv]
// stream_find_replace: byte stream find and replace
//
// req channel: one text byte per beat, in_last on the final byte of a text.
// rsp channel: rewritten bytes, one per beat; out_last on the final beat of
// a text; a text that rewrites to nothing yields one end marker beat with
// out_valid low. csr port: search/replace patterns (first byte in bits 7..0)
// and their lengths at byte addresses 0, 8, 16, 24; write only while idle.
// A byte taken into the input register is processed into the result buffer
// once that has room, and its first result beat is offered from there.
// Throughput: one byte per cycle while each byte yields at most one beat
// and rsp is not stalled; a byte that yields more beats holds the processing
// stage while the result buffer drains one beat per cycle that rsp is ready.
// The input register still takes one beat while results wait, so a stall
// on rsp fills the input register and then drops req_ready.
// Reset empties the window, the input register and the result buffer, and
// loads the patterns with zero, search length one and replace length zero.
`default_nettype none
`include "stream_find_replace_macros.svh"

module stream_find_replace #(
   parameter int PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF,
   parameter int REPLACE_MAX = sfr_pkg::REPLACE_MAX_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire sfr_pkg::req_type                 req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output sfr_pkg::rsp_type                      rsp_data,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [sfr_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [sfr_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [sfr_pkg::CSR_DATA_W-1:0]        prdata,
   output logic                                  pready
);
   import sfr_pkg::*;

   localparam int PAT_CAP   = (PATTERN_MAX < PAT_BYTES) ? PATTERN_MAX : PAT_BYTES;
   localparam int REP_CAP   = (REPLACE_MAX < PAT_BYTES) ? REPLACE_MAX : PAT_BYTES;
   localparam int RES_DEPTH = (PAT_CAP > REP_CAP) ? PAT_CAP : REP_CAP;
   localparam int CNT_W     = $clog2(PAT_CAP + 1);
   localparam int BUF_CW    = $clog2(RES_DEPTH + 1);

   // configuration registers
   logic [CSR_DATA_W-1:0] search_ff;
   logic [LEN_W-1:0]      slen_ff;
   logic [CSR_DATA_W-1:0] replace_ff;
   logic [LEN_W-1:0]      rlen_ff;
   logic                  csr_wr;
   csr_idx_type           csr_idx;

   // input register
   logic    in_vld_ff;
   req_type in_data_ff;

   // pending window
   logic [BYTE_W-1:0] win_ff [PAT_CAP];
   logic [BYTE_W-1:0] win_in [PAT_CAP];
   logic [CNT_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  cnt_in;

   // result buffer, head at entry zero
   rsp_type           buf_ff [RES_DEPTH];
   rsp_type           list_in [RES_DEPTH];
   logic [BUF_CW-1:0] buf_cnt_ff;
   logic [BUF_CW-1:0] buf_cnt_in;

   // processing signals
   logic [LEN_W-1:0]  slen;
   logic [LEN_W-1:0]  rlen;
   logic [LEN_W-1:0]  cnt_ext;
   logic [LEN_W-1:0]  cnt_app;
   logic [BYTE_W-1:0] win_app [PAT_CAP];
   logic [BYTE_W-1:0] rep_b [RES_DEPTH];
   logic [BYTE_W-1:0] win_b [RES_DEPTH];
   logic              hit;
   logic              match;
   logic              emit_one;
   logic              last;
   logic              marker;
   logic [LEN_W-1:0]  n_raw;
   logic [LEN_W-1:0]  n_res;
   logic              fire;
   logic              pop;
   logic              buf_free;

   // csr write decode and read mux
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = csr_idx_type'(paddr[CSR_ADDR_W-1:CSR_LSB]);

   always_ff @(posedge clock) begin
      if (reset) begin
         search_ff  <= '0;
         slen_ff    <= LEN_W'(1);
         replace_ff <= '0;
         rlen_ff    <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_SEARCH_PATTERN:  search_ff  <= pwdata;
            REG_SEARCH_LENGTH:   slen_ff    <= pwdata[LEN_W-1:0];
            REG_REPLACE_PATTERN: replace_ff <= pwdata;
            REG_REPLACE_LENGTH:  rlen_ff    <= pwdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_SEARCH_PATTERN:  prdata = search_ff;
         REG_SEARCH_LENGTH:   prdata = CSR_DATA_W'(slen_ff);
         REG_REPLACE_PATTERN: prdata = replace_ff;
         REG_REPLACE_LENGTH:  prdata = CSR_DATA_W'(rlen_ff);
         default:             prdata = '0;
      endcase
   end

   // effective lengths: a zero search length counts as one, both clamped to the window and replace limits
   always_comb begin
      slen = slen_ff;
      if (slen_ff == '0) begin
         slen = LEN_W'(1);
      end else if (slen_ff > LEN_W'(PAT_CAP)) begin
         slen = LEN_W'(PAT_CAP);
      end
      rlen = rlen_ff;
      if (rlen_ff > LEN_W'(REP_CAP)) begin
         rlen = LEN_W'(REP_CAP);
      end
   end

   // handshakes
   assign rsp_valid = buf_cnt_ff != '0;
   assign rsp_data  = buf_ff[0];
   assign pop       = rsp_valid && rsp_ready;
   assign buf_free  = (buf_cnt_ff == '0) || (buf_cnt_ff == BUF_CW'(1) && rsp_ready);
   assign fire      = in_vld_ff && buf_free;
   assign req_ready = !in_vld_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   // window with the new byte appended
   assign cnt_ext = LEN_W'(cnt_ff);
   assign cnt_app = (cnt_ff == CNT_W'(PAT_CAP)) ? cnt_ext : cnt_ext + LEN_W'(1);
   assign last    = in_data_ff.in_last;

   always_comb begin
      for (int j = 0; j < PAT_CAP; j++) begin
         win_app[j] = (LEN_W'(j) < cnt_ext) ? win_ff[j] : in_data_ff.in_byte;
      end
   end

   // compare the window, with the new byte appended, against the first slen bytes of the search pattern
   always_comb begin
      hit = 1'b1;
      for (int j = 0; j < PAT_CAP; j++) begin
         if (LEN_W'(j) < slen && win_app[j] != search_ff[BYTE_W*j +: BYTE_W]) begin
            hit = 1'b0;
         end
      end
   end

   assign match    = (cnt_app == slen) && hit;
   assign emit_one = !match && (cnt_app >= slen);

   // number of result beats for this byte
   always_comb begin
      priority if (match) begin
         n_raw = rlen;
      end else if (last) begin
         n_raw = cnt_app;
      end else if (emit_one) begin
         n_raw = LEN_W'(1);
      end else begin
         n_raw = '0;
      end
   end

   assign marker = last && (n_raw == '0);
   assign n_res  = marker ? LEN_W'(1) : n_raw;

   // source bytes per result slot
   for (genvar g = 0; g < RES_DEPTH; g++) begin : g_src
      if (g < REP_CAP) begin : g_rep
         assign rep_b[g] = replace_ff[BYTE_W*g +: BYTE_W];
      end else begin : g_norep
         assign rep_b[g] = '0;
      end
      if (g < PAT_CAP) begin : g_win
         assign win_b[g] = win_app[g];
      end else begin : g_nowin
         assign win_b[g] = '0;
      end
   end

   // result list: replacement on a match, end marker for an empty last, else the window from its oldest byte
   always_comb begin
      for (int j = 0; j < RES_DEPTH; j++) begin
         list_in[j].out_byte  = marker ? '0 : (match ? rep_b[j] : win_b[j]);
         list_in[j].out_valid = !marker;
         list_in[j].out_last  = last && (LEN_W'(j + 1) == n_res);
      end
   end

   // window after this byte
   for (genvar g = 0; g < PAT_CAP; g++) begin : g_win_nxt
      if (g + 1 < PAT_CAP) begin : g_shift
         assign win_in[g] = emit_one ? win_app[g + 1] : win_app[g];
      end else begin : g_top
         assign win_in[g] = win_app[g];
      end
   end

   always_comb begin
      priority if (match || last) begin
         cnt_in = '0;
      end else if (emit_one) begin
         cnt_in = CNT_W'(cnt_app - LEN_W'(1));
      end else begin
         cnt_in = CNT_W'(cnt_app);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (fire) begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         win_ff <= win_in;
      end
   end

   // result buffer: load a fresh list or shift out the head beat
   always_comb begin
      priority if (fire) begin
         buf_cnt_in = BUF_CW'(n_res);
      end else if (pop) begin
         buf_cnt_in = buf_cnt_ff - BUF_CW'(1);
      end else begin
         buf_cnt_in = buf_cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_cnt_ff <= '0;
      end else begin
         buf_cnt_ff <= buf_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         buf_ff <= list_in;
      end else if (pop) begin
         for (int j = 0; j + 1 < RES_DEPTH; j++) begin
            buf_ff[j] <= buf_ff[j + 1];
         end
      end
   end

   // checks
   `SFR_ASSERT_ALWAYS(a_buf_bound, clock, reset, buf_cnt_ff <= BUF_CW'(RES_DEPTH), "result buffer overfilled")
   `SFR_ASSERT_ALWAYS(a_win_room, clock, reset, cnt_ff < CNT_W'(PAT_CAP), "window left full between bytes")
   `SFR_ASSERT_NEXT(a_last_clears, clock, reset, fire && in_data_ff.in_last, cnt_ff == '0, "window not empty after last byte")
   `SFR_ASSERT_IMPL(a_marker_last, clock, reset, rsp_valid && !rsp_data.out_valid, rsp_data.out_last, "end marker without last flag")
   `SFR_ASSERT_NEXT(a_in_hold, clock, reset, in_vld_ff && !fire, in_vld_ff, "pending byte lost before processing")

endmodule

`default_nettype wire

[dv/stream_find_replace_test.sv]
`timescale 1ns / 1ps

module stream_find_replace_test;
   import sfr_pkg::*;

   localparam int WINDOW_CAP    = (PATTERN_MAX_DEF < PAT_BYTES) ? PATTERN_MAX_DEF : PAT_BYTES;
   localparam int REPLACE_CAP   = (REPLACE_MAX_DEF < PAT_BYTES) ? REPLACE_MAX_DEF : PAT_BYTES;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_REPORTS   = 10;
   localparam int NUM_PHASES    = 12;
   localparam int PHASE_BYTES   = 38;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr     = '0;
   logic [CSR_DATA_W-1:0] pwdata    = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // text bytes waiting to be sent and rewritten beats still to arrive
   req_type text_queue[$];
   rsp_type rewritten_queue[$];
   int      bytes_queued   = 0;
   int      bytes_accepted = 0;
   int      mismatch_count = 0;
   int      cycle_count    = 0;
   int      sender_idle_pct    = 0;
   int      receiver_stall_pct = 0;

   // predictor copy of the rewrite rule and the pending window
   logic [63:0] rule_search      = '0;
   logic [3:0]  rule_search_len  = 4'd1;
   logic [63:0] rule_replace     = '0;
   logic [3:0]  rule_replace_len = '0;
   logic [7:0]  window_bytes [WINDOW_CAP];
   int          window_fill = 0;

   // small alphabet so random text hits the search pattern often
   logic [7:0]  glyphs [4];

   stream_find_replace u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("stream_find_replace regression: fail");
         $finish;
      end
   end

   // search length in effect: zero counts as one, capped at the window size
   function automatic int search_span();
      int n;
      n = rule_search_len;
      if (n < 1) n = 1;
      if (n > WINDOW_CAP) n = WINDOW_CAP;
      return n;
   endfunction

   // advance the window by one text byte and queue the beats it yields
   function automatic void rewrite_byte(req_type beat);
      rsp_type produced[$];
      int      span;
      int      reps;
      bit      hit;
      bit      spill;
      span  = search_span();
      spill = 1'b0;
      if (window_fill < WINDOW_CAP) begin
         window_bytes[window_fill] = beat.in_byte;
         window_fill++;
      end
      if (window_fill == span) begin
         hit = 1'b1;
         for (int i = 0; i < span; i++)
            if (window_bytes[i] != rule_search[8*i +: 8]) hit = 1'b0;
         if (hit) begin
            reps = (rule_replace_len > REPLACE_CAP) ? REPLACE_CAP : rule_replace_len;
            for (int i = 0; i < reps; i++)
               produced.push_back(rsp_type'{out_byte: rule_replace[8*i +: 8],
                                            out_valid: 1'b1, out_last: 1'b0});
            window_fill = 0;
         end else begin
            spill = 1'b1;
         end
      end else if (window_fill > span) begin
         spill = 1'b1;
      end
      // oldest byte leaves unchanged
      if (spill) begin
         produced.push_back(rsp_type'{out_byte: window_bytes[0], out_valid: 1'b1,
                                      out_last: 1'b0});
         for (int i = 0; i + 1 < window_fill; i++) window_bytes[i] = window_bytes[i+1];
         window_fill--;
      end
      // final byte flushes the window, end marker if nothing came out
      if (beat.in_last) begin
         for (int i = 0; i < window_fill; i++)
            produced.push_back(rsp_type'{out_byte: window_bytes[i], out_valid: 1'b1,
                                         out_last: 1'b0});
         window_fill = 0;
         if (produced.size() == 0)
            produced.push_back(rsp_type'{out_byte: 8'h00, out_valid: 1'b0, out_last: 1'b0});
         produced[produced.size()-1].out_last = 1'b1;
      end
      foreach (produced[i]) rewritten_queue.push_back(produced[i]);
   endfunction

   function automatic void note_mismatch(string what, rsp_type want, rsp_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t %s: expected byte %02h valid %0b last %0b, got byte %02h valid %0b last %0b",
                  $time, what, want.out_byte, want.out_valid, want.out_last,
                  got.out_byte, got.out_valid, got.out_last);
   endfunction

   // req driver: new beat only once the previous one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (text_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= text_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // rsp backpressure
   always @(posedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= receiver_stall_pct);
   end

   // monitor: check rsp beats, then predict from accepted req beats
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (rewritten_queue.size() == 0) begin
               note_mismatch("beat with nothing expected", '0, rsp_data);
            end else begin
               want = rewritten_queue.pop_front();
               if (want.out_byte !== rsp_data.out_byte || want.out_valid !== rsp_data.out_valid ||
                   want.out_last !== rsp_data.out_last)
                  note_mismatch("rewritten beat", want, rsp_data);
            end
         end
         if (req_valid && req_ready) begin
            rewrite_byte(req_data);
            bytes_accepted <= bytes_accepted + 1;
         end
      end
   end

   function automatic void queue_byte(logic [7:0] b, logic last);
      text_queue.push_back(req_type'{in_byte: b, in_last: last});
      bytes_queued++;
   endfunction

   // csr write: setup then access, register taken when pready is high
   task automatic csr_write(input csr_idx_type idx, input logic [63:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, {CSR_LSB{1'b0}}};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_SEARCH_PATTERN:  rule_search      = value;
         REG_SEARCH_LENGTH:   rule_search_len  = value[3:0];
         REG_REPLACE_PATTERN: rule_replace     = value;
         REG_REPLACE_LENGTH:  rule_replace_len = value[3:0];
         default: ;
      endcase
   endtask

   task automatic load_rule(input logic [63:0] search, input logic [3:0] slen,
                            input logic [63:0] replace, input logic [3:0] rlen);
      csr_write(REG_SEARCH_PATTERN, search);
      csr_write(REG_SEARCH_LENGTH, 64'(slen));
      csr_write(REG_REPLACE_PATTERN, replace);
      csr_write(REG_REPLACE_LENGTH, 64'(rlen));
   endtask

   // all bytes taken, all beats seen, then let the pipeline settle
   task automatic wait_for_drain();
      do @(posedge clock);
      while (bytes_accepted != bytes_queued || rewritten_queue.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // random text: whole occurrences, broken prefixes, alphabet and raw noise
   task automatic queue_text(input int count);
      int made;
      int r;
      int span;
      int cut;
      span = search_span();
      made = 0;
      while (made < count) begin
         r = $urandom_range(99);
         if (r < 45) begin
            for (int k = 0; k < span; k++) begin
               queue_byte(rule_search[8*k +: 8], $urandom_range(11) == 0);
               made++;
            end
         end else if (r < 60 && span > 1) begin
            cut = $urandom_range(span - 1, 1);
            for (int k = 0; k < cut; k++) begin
               queue_byte(rule_search[8*k +: 8], $urandom_range(11) == 0);
               made++;
            end
         end else if (r < 85) begin
            queue_byte(glyphs[$urandom_range(3)], $urandom_range(11) == 0);
            made++;
         end else begin
            queue_byte(8'($urandom), $urandom_range(11) == 0);
            made++;
         end
      end
   endtask

   initial begin
      int          phase;
      int          r;
      logic [63:0] search;
      logic [3:0]  slen;
      logic [3:0]  rlen;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // two-byte search, three-byte replacement, byte extremes
      load_rule(64'hFF00, 4'd2, 64'h5A00FF, 4'd3);
      @(negedge clock);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h7A, 1'b1);

      // deletion: a text that rewrites to nothing, then a lone short text
      wait_for_drain();
      csr_write(REG_REPLACE_LENGTH, 64'd0);
      @(negedge clock);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b1);
      queue_byte(8'hFF, 1'b1);

      // zero search length acts as one, oversized replace length saturates
      wait_for_drain();
      csr_write(REG_SEARCH_LENGTH, 64'd0);
      csr_write(REG_REPLACE_PATTERN, '1);
      csr_write(REG_REPLACE_LENGTH, 64'd15);
      @(negedge clock);
      queue_byte(8'h00, 1'b1);
      queue_byte(8'h55, 1'b1);

      // oversized search length saturates to the full window
      wait_for_drain();
      load_rule('1, 4'd15, 64'h0, 4'd1);
      @(negedge clock);
      for (int k = 0; k < 7; k++) queue_byte(8'hFF, 1'b0);
      queue_byte(8'hFF, 1'b1);

      // search length lowered while bytes are pending
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h01, 1'b0);
      queue_byte(8'h02, 1'b0);
      wait_for_drain();
      csr_write(REG_SEARCH_LENGTH, 64'd1);
      @(negedge clock);
      queue_byte(8'h03, 1'b0);
      queue_byte(8'hFF, 1'b1);

      // random phases, new rule and idling pattern each time
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         wait_for_drain();
         foreach (glyphs[k]) glyphs[k] = 8'($urandom);
         for (int k = 0; k < 8; k++) search[8*k +: 8] = glyphs[$urandom_range(3)];
         r = $urandom_range(19);
         if (phase == 0) slen = 4'd1;
         else if (phase == 1) slen = 4'd8;
         else if (r == 0) slen = 4'd0;
         else if (r == 1) slen = 4'($urandom_range(15, 9));
         else slen = 4'($urandom_range(8, 1));
         r = $urandom_range(19);
         if (phase == 0) rlen = 4'd8;
         else if (phase == 1) rlen = 4'd0;
         else if (r == 0) rlen = 4'($urandom_range(15, 9));
         else rlen = 4'($urandom_range(8, 0));
         load_rule(search, slen, {$urandom, $urandom}, rlen);
         @(negedge clock);
         case (phase % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 87; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 87; end
            default: begin sender_idle_pct = 33; receiver_stall_pct = 33; end
         endcase
         queue_text(PHASE_BYTES);
      end

      wait_for_drain();
      repeat (16) @(posedge clock);
      if (mismatch_count == 0)
         $display("stream_find_replace regression: pass");
      else
         $display("stream_find_replace regression: fail");
      $finish;
   end

endmodule
